>>> hw/rtl/current_sense_offset_trip_unit_defines.svh
// assertion macros for the checker file of the current sense unit
// no dependencies; pulled in by `include where assertions are written
`ifndef CURRENT_SENSE_OFFSET_TRIP_UNIT_DEFINES_SVH
`define CURRENT_SENSE_OFFSET_TRIP_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define CSOT_ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("same-cycle check failed");

// condition implies consequence in the next cycle
`define CSOT_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hw/rtl/csot_pkg.sv
// package for the current sense offset / trip unit: widths, constants, codes
// no dependencies; used by the top level and its checker
package csot_pkg;

	localparam int SAMPLE_COUNT = 64;
	localparam int AVG_SHIFT    = 6;
	localparam int CNT_W        = $clog2(SAMPLE_COUNT + 1);

	localparam int SAMPLE_W  = 10;
	localparam int SUM_W     = 16;
	localparam int LIMIT_W   = 15;
	localparam int GAIN_W    = 16;
	localparam int CUR_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int GAIN_FRAC = 10;

	localparam logic [SAMPLE_W-1:0] OFFSET_TOP = '1;

	localparam logic [LIMIT_W-1:0]  RST_OC_LIMIT = LIMIT_W'(10000);
	localparam logic [GAIN_W-1:0]   RST_GAIN     = GAIN_W'(50000);
	localparam logic [SAMPLE_W-1:0] RST_OFF_MIN  = SAMPLE_W'(400);
	localparam logic [SAMPLE_W-1:0] RST_OFF_MAX  = SAMPLE_W'(624);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OC_LIMIT = 2'd0,
		REG_GAIN     = 2'd1,
		REG_OFF_MIN  = 2'd2,
		REG_OFF_MAX  = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ACT_CAL  = 1'b0,
		ACT_MEAS = 1'b1
	} action_t;

endpackage

>>> hw/rtl/current_sense_offset_trip_unit.sv
// current sense offset calibration, scaling and overcurrent trip
// depends on csot_pkg
//
// usage:
//   input channel (in_valid/in_ready): one beat per adc sample, tagged by
//   action as a calibration or a measurement sample, plus powered_up
//   output channel (out_valid/out_ready): one result beat per input beat,
//   in order: current_ma, cal_done and the offset / trip / fault status
//   after that sample
//   config channel (cfg_valid/cfg_ready): register index and data, always
//   ready; write only while no sample is in flight
// latency: 2 cycles from input beat to result beat (input register, then
//   result register); one 11x17 multiply and its compares sit between them
// throughput: 1 beat per cycle, with out_ready held high
// stall: when out_ready is low the result register holds; one more beat
//   is taken into the input register, then in_ready drops until the
//   result is taken
// reset: clears both stages, the running sum and the latches, reloads the
//   countdown and puts the config registers at their defaults
module current_sense_offset_trip_unit
	import csot_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// sample channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       action,
	input  logic [SAMPLE_W-1:0]        sample,
	input  logic                       powered_up,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [CUR_W-1:0]    current_ma,
	output logic                       cal_done,
	output logic [SAMPLE_W-1:0]        offset_code,
	output logic                       overcurrent_flag,
	output logic                       offset_fault,
	// config channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DAT_W-1:0]       cfg_data
);

	// config registers
	logic [LIMIT_W-1:0]  oc_limit_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [SAMPLE_W-1:0] off_min_q;
	logic [SAMPLE_W-1:0] off_max_q;

	// calibration and trip state
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] offset_q;
	logic                trip_q;
	logic                fault_q;

	// input stage
	logic                valid_s1;
	action_t             action_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                pwr_s1;

	// result stage
	logic                    valid_s2;
	logic signed [CUR_W-1:0] cur_s2;
	logic                    done_s2;

	logic advance;
	logic take_in;

	// stage 1 moves on when the result register is free or being emptied
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign take_in   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// ---------------- calibration path ----------------
	logic [SUM_W-1:0] avg;
	logic             cal_close;
	logic [SUM_W-1:0] sum_add;
	logic [SAMPLE_W-1:0] avg_sat;
	logic             win_bad;

	assign avg       = sum_q >> AVG_SHIFT;
	assign cal_close = (cnt_q == '0);
	assign sum_add   = sum_q + {{(SUM_W-SAMPLE_W){1'b0}}, sample_s1};
	// average above the 10-bit range pins the offset at full scale
	assign avg_sat   = (avg > {{(SUM_W-SAMPLE_W){1'b0}}, OFFSET_TOP}) ?
		OFFSET_TOP : avg[SAMPLE_W-1:0];
	// window test uses the unsaturated average; an inverted window always fails
	assign win_bad   = (avg < {{(SUM_W-SAMPLE_W){1'b0}}, off_min_q}) ||
		(avg > {{(SUM_W-SAMPLE_W){1'b0}}, off_max_q});

	// ---------------- measurement path ----------------
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + GAIN_W + 1;
	localparam int SHR_W  = PROD_W - GAIN_FRAC;
	localparam int CMP_W  = CUR_W + 2;

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [SHR_W-1:0]  shr;
	logic signed [CUR_W-1:0]  cur_sat;
	logic [CUR_W-1:0]         lim;
	logic signed [CMP_W-1:0]  cur_ext;
	logic signed [CMP_W-1:0]  lim_ext;
	logic                     trip_hit;

	localparam logic signed [SHR_W-1:0] CUR_HI = SHR_W'((1 << (CUR_W - 1)) - 1);
	localparam logic signed [SHR_W-1:0] CUR_LO = -SHR_W'(1 << (CUR_W - 1));

	assign diff = $signed({1'b0, sample_s1}) - $signed({1'b0, offset_q});
	assign prod = diff * $signed({1'b0, gain_q});
	// dropping the low bits of a two's complement value is a floor shift
	assign shr  = $signed(prod[PROD_W-1:GAIN_FRAC]);

	always_comb begin
		if (shr > CUR_HI) begin
			cur_sat = {1'b0, {(CUR_W-1){1'b1}}};
		end else if (shr < CUR_LO) begin
			cur_sat = {1'b1, {(CUR_W-1){1'b0}}};
		end else begin
			cur_sat = shr[CUR_W-1:0];
		end
	end

	// limit is offset plus margin at full width, tested against +/- lim
	assign lim      = {{(CUR_W-SAMPLE_W){1'b0}}, offset_q} + {1'b0, oc_limit_q};
	assign cur_ext  = {{(CMP_W-CUR_W){cur_sat[CUR_W-1]}}, cur_sat};
	assign lim_ext  = $signed({{(CMP_W-CUR_W){1'b0}}, lim});
	assign trip_hit = pwr_s1 && ((cur_ext > lim_ext) || (cur_ext < -lim_ext));

	// ---------------- config registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_limit_q <= RST_OC_LIMIT;
			gain_q     <= RST_GAIN;
			off_min_q  <= RST_OFF_MIN;
			off_max_q  <= RST_OFF_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_OC_LIMIT: oc_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_GAIN:     gain_q     <= cfg_data[GAIN_W-1:0];
				REG_OFF_MIN:  off_min_q  <= cfg_data[SAMPLE_W-1:0];
				REG_OFF_MAX:  off_max_q  <= cfg_data[SAMPLE_W-1:0];
				default:      ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1 <= action_t'(action);
			sample_s1 <= sample;
			pwr_s1    <= powered_up;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			if (action_s1 == ACT_MEAS) begin
				cur_s2  <= cur_sat;
				done_s2 <= 1'b0;
			end else begin
				cur_s2  <= '0;
				done_s2 <= cal_close;
			end
		end
	end

	// ---------------- calibration / trip state ----------------
	// state moves only together with the result register, so the status
	// outputs below stay stable while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			cnt_q    <= CNT_W'(SAMPLE_COUNT);
			offset_q <= '0;
			trip_q   <= 1'b0;
			fault_q  <= 1'b0;
		end else if (advance) begin
			if (action_s1 == ACT_CAL) begin
				if (cal_close) begin
					// round closed: this sample is dropped
					offset_q <= avg_sat;
					sum_q    <= '0;
					cnt_q    <= CNT_W'(SAMPLE_COUNT);
					if (win_bad) begin
						fault_q <= 1'b1;
					end
				end else begin
					sum_q <= sum_add;
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end else if (trip_hit) begin
				trip_q <= 1'b1;
			end
		end
	end

	assign out_valid        = valid_s2;
	assign current_ma       = cur_s2;
	assign cal_done         = done_s2;
	assign offset_code      = offset_q;
	assign overcurrent_flag = trip_q;
	assign offset_fault     = fault_q;

endmodule

>>> hw/rtl/csot_checker.sv
// port-level checker for the current sense unit, bound to the top level
// depends on csot_pkg and current_sense_offset_trip_unit_defines.svh
`include "current_sense_offset_trip_unit_defines.svh"

module csot_checker
	import csot_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [CUR_W-1:0] current_ma,
	input logic                    cal_done,
	input logic [SAMPLE_W-1:0]     offset_code,
	input logic                    overcurrent_flag,
	input logic                    offset_fault
);

	// trip and fault latches only clear on reset
	`CSOT_ASSERT_NEXT(a_trip_sticky, clk, arst_n, overcurrent_flag, overcurrent_flag)
	`CSOT_ASSERT_NEXT(a_fault_sticky, clk, arst_n, offset_fault, offset_fault)

	// a closing calibration beat carries no current
	`CSOT_ASSERT_SAME(a_done_zero_cur, clk, arst_n, out_valid && cal_done, current_ma == '0)

	// a stalled result beat holds its current, cal_done and offset code
	`CSOT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(current_ma) && $stable(cal_done) && $stable(offset_code))

endmodule

bind current_sense_offset_trip_unit csot_checker u_csot_checker (.*);
